// ----- rtl/bps_pkg.sv -----
package bps_pkg;

	// Image and arithmetic sizing.
	localparam int IMAGE_BYTES   = 65536;
	localparam int FRACTION_BITS = 8;
	localparam int ADDR_W        = $clog2(IMAGE_BYTES);
	localparam int COORD_W       = 20;
	localparam int INT_W         = COORD_W - FRACTION_BITS;
	localparam int STRIDE_W      = 16;
	localparam int WEIGHT_W      = FRACTION_BITS + 1;
	localparam int ROW_W         = 8 + FRACTION_BITS;
	localparam int SUM_W         = 8 + 2 * FRACTION_BITS;
	localparam int MUL_W         = (STRIDE_W + INT_W + 1 > ADDR_W) ?
		(STRIDE_W + INT_W + 1) : ADDR_W;
	localparam int NUM_CH        = 3;

	// Operation codes and register indexes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam logic REG_CHANNEL_MODE = 1'b0;
	localparam logic REG_ROW_STRIDE   = 1'b1;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd256;

	typedef struct packed {
		logic                      operation;
		logic [15:0]               write_address;
		logic [7:0]                write_data;
		logic signed [COORD_W-1:0] coord_row;
		logic signed [COORD_W-1:0] coord_col;
	} bps_in_t;

	typedef struct packed {
		logic [7:0] channel_zero;
		logic [7:0] channel_one;
		logic [7:0] channel_two;
	} bps_out_t;

	// Third address stage, handed from address generation to memory and blend.
	typedef struct packed {
		logic                     valid;
		logic                     operation;
		logic                     mode;
		logic [ADDR_W-1:0]        wr_addr;
		logic [7:0]               wr_data;
		logic [FRACTION_BITS-1:0] fr;
		logic [FRACTION_BITS-1:0] fc;
		logic [ADDR_W-1:0]        a00;
		logic [ADDR_W-1:0]        a01;
		logic [ADDR_W-1:0]        a10;
		logic [ADDR_W-1:0]        a11;
	} bps_s3_t;

endpackage

// ----- rtl/bps_ram.sv -----
module bps_ram import bps_pkg::*; #(
	parameter int DEPTH_W = 16,
	parameter int DATA_W  = 8
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [DEPTH_W-1:0] waddr,
	input  logic [DATA_W-1:0]  wdata,
	input  logic [DEPTH_W-1:0] raddr_a,
	input  logic [DEPTH_W-1:0] raddr_b,
	output logic [DATA_W-1:0]  rdata_a,
	output logic [DATA_W-1:0]  rdata_b
);

	logic [DATA_W-1:0] mem_q [(1 << DEPTH_W)];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (en) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ----- rtl/bps_addr.sv -----
module bps_addr import bps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  bps_in_t             in_data,
	input  logic                mode,
	input  logic [STRIDE_W-1:0] stride,
	output bps_s3_t             s3
);

	logic                 v_s1, op_s1;
	logic [ADDR_W-1:0]    wa_s1;
	logic [7:0]           wd_s1;
	logic [COORD_W-1:0]   ar_s1, ac_s1;
	logic [COORD_W-1:0]   ar_in, ac_in;

	logic                     v_s2, op_s2, mode_s2;
	logic [ADDR_W-1:0]        wa_s2;
	logic [7:0]               wd_s2;
	logic [FRACTION_BITS-1:0] fr_s2, fc_s2;
	logic [ADDR_W-1:0]        r0_s2, r1_s2, c0_s2, c1_s2;

	logic [INT_W:0]   ir0, ir1, ic0, ic1;
	logic [MUL_W-1:0] r0_p, r1_p, c0_p, c1_p;

	// Absolute values of the coordinates; the most negative value stays exact.
	assign ar_in = in_data.coord_row[COORD_W-1] ? (~in_data.coord_row + 1'b1)
		: in_data.coord_row;
	assign ac_in = in_data.coord_col[COORD_W-1] ? (~in_data.coord_col + 1'b1)
		: in_data.coord_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage one: capture the beat and fold the coordinates.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= in_data.operation;
			wa_s1 <= ADDR_W'(in_data.write_address);
			wd_s1 <= in_data.write_data;
			ar_s1 <= ar_in;
			ac_s1 <= ac_in;
		end
	end

	// Integer neighbors; the upper one steps only when a fraction is present.
	assign ir0 = {1'b0, ar_s1[COORD_W-1:FRACTION_BITS]};
	assign ic0 = {1'b0, ac_s1[COORD_W-1:FRACTION_BITS]};
	assign ir1 = ir0 + (INT_W+1)'(|ar_s1[FRACTION_BITS-1:0]);
	assign ic1 = ic0 + (INT_W+1)'(|ac_s1[FRACTION_BITS-1:0]);

	// Row offsets multiply by the stride, column offsets by one or three.
	assign r0_p = MUL_W'(stride) * MUL_W'(ir0);
	assign r1_p = MUL_W'(stride) * MUL_W'(ir1);
	assign c0_p = mode ? ((MUL_W'(ic0) << 1) + MUL_W'(ic0)) : MUL_W'(ic0);
	assign c1_p = mode ? ((MUL_W'(ic1) << 1) + MUL_W'(ic1)) : MUL_W'(ic1);

	// Stage two: products, reduced to the memory address width.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			mode_s2 <= mode;
			wa_s2   <= wa_s1;
			wd_s2   <= wd_s1;
			fr_s2   <= ar_s1[FRACTION_BITS-1:0];
			fc_s2   <= ac_s1[FRACTION_BITS-1:0];
			r0_s2   <= r0_p[ADDR_W-1:0];
			r1_s2   <= r1_p[ADDR_W-1:0];
			c0_s2   <= c0_p[ADDR_W-1:0];
			c1_s2   <= c1_p[ADDR_W-1:0];
		end
	end

	// Stage three: the four corner base addresses, wrapping naturally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3 <= '0;
		end else if (adv) begin
			s3.valid     <= v_s2;
			s3.operation <= op_s2;
			s3.mode      <= mode_s2;
			s3.wr_addr   <= wa_s2;
			s3.wr_data   <= wd_s2;
			s3.fr        <= fr_s2;
			s3.fc        <= fc_s2;
			s3.a00       <= r0_s2 + c0_s2;
			s3.a01       <= r0_s2 + c1_s2;
			s3.a10       <= r1_s2 + c0_s2;
			s3.a11       <= r1_s2 + c1_s2;
		end
	end

endmodule

// ----- rtl/bps_blend.sv -----
module bps_blend import bps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  bps_s3_t    s3,
	input  logic [7:0] tl [NUM_CH],
	input  logic [7:0] tr [NUM_CH],
	input  logic [7:0] bl [NUM_CH],
	input  logic [7:0] br [NUM_CH],
	output logic       out_valid,
	output bps_out_t   out_data
);

	localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << FRACTION_BITS;

	logic                     v_s4, mode_s4, v_s5, mode_s5;
	logic [FRACTION_BITS-1:0] fr_s4, fc_s4, fr_s5;
	logic [ROW_W-1:0]         top_s5 [NUM_CH];
	logic [ROW_W-1:0]         bot_s5 [NUM_CH];
	logic [ROW_W-1:0]         top_c [NUM_CH];
	logic [ROW_W-1:0]         bot_c [NUM_CH];
	logic [SUM_W-1:0]         sum_c [NUM_CH];
	logic [WEIGHT_W-1:0]      wc0, wc1, wr0, wr1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s4 <= s3.valid && (s3.operation == OP_SAMPLE);
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	// Stage four: weights ride alongside the pixels read from memory.
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s4 <= s3.mode;
			fr_s4   <= s3.fr;
			fc_s4   <= s3.fc;
		end
	end

	assign wc1 = WEIGHT_W'(fc_s4);
	assign wc0 = ONE - wc1;
	assign wr1 = WEIGHT_W'(fr_s5);
	assign wr0 = ONE - wr1;

	// Horizontal blend of each row, then vertical blend of the two rows.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			top_c[c] = ROW_W'(ROW_W'(tl[c]) * ROW_W'(wc0) + ROW_W'(tr[c]) * ROW_W'(wc1));
			bot_c[c] = ROW_W'(ROW_W'(bl[c]) * ROW_W'(wc0) + ROW_W'(br[c]) * ROW_W'(wc1));
			sum_c[c] = SUM_W'(SUM_W'(top_s5[c]) * SUM_W'(wr0)
				+ SUM_W'(bot_s5[c]) * SUM_W'(wr1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s5 <= mode_s4;
			fr_s5   <= fr_s4;
			for (int c = 0; c < NUM_CH; c++) begin
				top_s5[c] <= top_c[c];
				bot_s5[c] <= bot_c[c];
			end
		end
	end

	// Stage six: result register; upper channels read zero in grayscale.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.channel_zero <= sum_c[0][SUM_W-1 -: 8];
			out_data.channel_one  <= mode_s5 ? sum_c[1][SUM_W-1 -: 8] : 8'd0;
			out_data.channel_two  <= mode_s5 ? sum_c[2][SUM_W-1 -: 8] : 8'd0;
		end
	end

endmodule

// ----- rtl/bilinear_pixel_sampler.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    bps_in_t: write or sample beat
// out       output     out_valid/out_stall  bps_out_t: three channel bytes
// cfg       input      APB psel/penable     channel_mode, row_stride
//
// One beat enters every cycle unless a held result stalls the pipeline.
// The rate is set by six replicated image memories, each with two read ports.
// Reset clears the valid bits and the configuration registers; image memory is not cleared.
// A stalled result freezes the whole pipeline, so no beat is lost or repeated.
module bilinear_pixel_sampler import bps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  bps_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output bps_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                mode_q;
	logic [STRIDE_W-1:0] stride_q;
	logic                adv, ram_we;
	bps_s3_t             s3;
	logic [7:0]          tl [NUM_CH];
	logic [7:0]          tr [NUM_CH];
	logic [7:0]          bl [NUM_CH];
	logic [7:0]          br [NUM_CH];

	// Register file.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			stride_q <= STRIDE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_CHANNEL_MODE: mode_q   <= pwdata[0];
				REG_ROW_STRIDE:   stride_q <= pwdata[STRIDE_W-1:0];
				default:          mode_q   <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CHANNEL_MODE: prdata = {31'd0, mode_q};
			REG_ROW_STRIDE:   prdata = {{(32-STRIDE_W){1'b0}}, stride_q};
			default:          prdata = 32'd0;
		endcase
	end

	// The pipeline moves unless a finished result is held back.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign ram_we   = adv && s3.valid && (s3.operation == OP_WRITE);

	bps_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.mode     (mode_q),
		.stride   (stride_q),
		.s3       (s3)
	);

	// Two memory copies per channel: one for the top row, one for the bottom.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		bps_ram #(.DEPTH_W(ADDR_W), .DATA_W(8)) u_top (
			.clk     (clk),
			.en      (adv),
			.we      (ram_we),
			.waddr   (s3.wr_addr),
			.wdata   (s3.wr_data),
			.raddr_a (s3.a00 + ADDR_W'(c)),
			.raddr_b (s3.a01 + ADDR_W'(c)),
			.rdata_a (tl[c]),
			.rdata_b (tr[c])
		);
		bps_ram #(.DEPTH_W(ADDR_W), .DATA_W(8)) u_bot (
			.clk     (clk),
			.en      (adv),
			.we      (ram_we),
			.waddr   (s3.wr_addr),
			.wdata   (s3.wr_data),
			.raddr_a (s3.a10 + ADDR_W'(c)),
			.raddr_b (s3.a11 + ADDR_W'(c)),
			.rdata_a (bl[c]),
			.rdata_b (br[c])
		);
	end

	bps_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.s3        (s3),
		.tl        (tl),
		.tr        (tr),
		.bl        (bl),
		.br        (br),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Back pressure comes only from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// Memory is written only while the pipeline advances.
	a_write_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !in_stall)
		else $error("memory written during a stall");

	// Grayscale results carry zero in the upper channels.
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_q) |-> (out_data.channel_one == 8'd0
			&& out_data.channel_two == 8'd0))
		else $error("grayscale result with nonzero upper channel");

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import bps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks image contents and register settings, and predicts each sampled pixel.
	class pixel_scoreboard;
		logic [7:0]    image [IMAGE_BYTES];
		bit            written [IMAGE_BYTES];
		bit            three_ch;
		int unsigned   stride;
		bps_out_t      pending[$];
		int            errors;
		int            samples_checked;
		int            writes_seen;

		function void reset_state();
			three_ch = 1'b0;
			stride = 256;
			errors = 0;
			samples_checked = 0;
			writes_seen = 0;
		endfunction

		function int unsigned magnitude(logic [COORD_W-1:0] v);
			if (v[COORD_W-1])
				return (1 << COORD_W) - int'(v);
			return int'(v);
		endfunction

		// Byte address of one corner (0 top left .. 3 bottom right) for one channel.
		function logic [15:0] corner_addr(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
				int corner, int ch);
			int unsigned ar, ac, ri, ci;
			longint unsigned a;
			ar = magnitude(r);
			ac = magnitude(c);
			ri = (ar >> FRACTION_BITS) + ((corner >= 2 && ar[7:0] != 0) ? 1 : 0);
			ci = (ac >> FRACTION_BITS) + ((corner[0] && ac[7:0] != 0) ? 1 : 0);
			a = longint'(stride) * ri + (three_ch ? 3 : 1) * ci + ch;
			return a[15:0];
		endfunction

		function logic [7:0] blend_channel(bps_in_t b, int ch);
			longint unsigned s, fr, fc, sum;
			s = 1 << FRACTION_BITS;
			fr = magnitude(b.coord_row) & (s - 1);
			fc = magnitude(b.coord_col) & (s - 1);
			sum = image[corner_addr(b.coord_row, b.coord_col, 0, ch)] * (s - fr) * (s - fc)
				+ image[corner_addr(b.coord_row, b.coord_col, 1, ch)] * (s - fr) * fc
				+ image[corner_addr(b.coord_row, b.coord_col, 2, ch)] * fr * (s - fc)
				+ image[corner_addr(b.coord_row, b.coord_col, 3, ch)] * fr * fc;
			return sum[2*FRACTION_BITS +: 8];
		endfunction

		function void note_beat(bps_in_t b);
			bps_out_t e;
			if (b.operation == OP_WRITE) begin
				image[b.write_address] = b.write_data;
				written[b.write_address] = 1'b1;
				writes_seen++;
				return;
			end
			e = '0;
			e.channel_zero = blend_channel(b, 0);
			if (three_ch) begin
				e.channel_one = blend_channel(b, 1);
				e.channel_two = blend_channel(b, 2);
			end
			pending.push_back(e);
		endfunction

		function void check_result(bps_out_t got);
			bps_out_t e;
			if (pending.size() == 0) begin
				$error("pixel result with nothing expected: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			samples_checked++;
			if (got.channel_zero !== e.channel_zero) begin
				$error("channel_zero expected %0d actual %0d", e.channel_zero, got.channel_zero);
				errors++;
			end
			if (got.channel_one !== e.channel_one) begin
				$error("channel_one expected %0d actual %0d", e.channel_one, got.channel_one);
				errors++;
			end
			if (got.channel_two !== e.channel_two) begin
				$error("channel_two expected %0d actual %0d", e.channel_two, got.channel_two);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	bps_in_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	bps_out_t    out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pixel_scoreboard sb = new();
	bit          steady_send;
	bit          send_done;

	bilinear_pixel_sampler dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none while streaming steadily.
	function int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one input beat and hold it until accepted.
	task automatic send_beat(bps_in_t b);
		int gap;
		gap = pick_gap(steady_send);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = b;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_byte(logic [15:0] a, logic [7:0] d);
		bps_in_t b;
		b = '0;
		b.operation = OP_WRITE;
		b.write_address = a;
		b.write_data = d;
		b.coord_row = COORD_W'($urandom);
		b.coord_col = COORD_W'($urandom);
		send_beat(b);
	endtask

	// Fill any neighbor bytes not yet written, then send the sample.
	task automatic sample_at(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
		bps_in_t b;
		logic [15:0] a;
		for (int ch = 0; ch < (sb.three_ch ? 3 : 1); ch++)
			for (int k = 0; k < 4; k++) begin
				a = sb.corner_addr(r, c, k, ch);
				if (!sb.written[a])
					write_byte(a, 8'($urandom));
			end
		b = '0;
		b.operation = OP_SAMPLE;
		b.write_address = 16'($urandom);
		b.write_data = 8'($urandom);
		b.coord_row = r;
		b.coord_col = c;
		send_beat(b);
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (a == 3'(4 * REG_CHANNEL_MODE))
			sb.three_ch = d[0];
		else
			sb.stride = d[15:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(bit mode, int unsigned stride);
		wait_idle();
		reg_write(3'(4 * REG_CHANNEL_MODE), {31'b0, mode});
		reg_write(3'(4 * REG_ROW_STRIDE), stride);
	endtask

	function logic [COORD_W-1:0] random_coord();
		if ($urandom_range(0, 9) < 6)
			return COORD_W'($urandom);
		return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				steady_send = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 3)
				write_byte(16'($urandom), 8'($urandom));
			else
				sample_at(random_coord(), random_coord());
		end
		steady_send = 1'b0;
	endtask

	// Result side: random stall with stretches of none.
	initial begin
		int calm;
		calm = 0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				calm--;
				out_stall = 1'b0;
			end else if ($urandom_range(0, 99) < 3) begin
				calm = $urandom_range(20, 80);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 99) < 3) begin
				out_stall = 1'b1;
				repeat ($urandom_range(10, 30)) @(negedge clk);
			end else begin
				out_stall = ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		sb.reset_state();
		steady_send = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: byte extremes, coordinate extremes, whole and fractional points.
		write_byte(16'h0000, 8'hFF);
		write_byte(16'hFFFF, 8'h00);
		write_byte(16'h0001, 8'h00);
		write_byte(16'h0100, 8'hFF);
		write_byte(16'h0101, 8'h80);
		sample_at(20'sd0, 20'sd0);
		sample_at(20'sd255, 20'sd255);
		sample_at(20'sd128, -20'sd128);
		sample_at(-20'sd524288, -20'sd524288);
		sample_at(20'sd524287, 20'sd524287);
		sample_at(-20'sd1, 20'sd1);
		sample_at(20'sd256, 20'sd512);
		sample_at(20'sd524287, -20'sd524288);
		configure(1'b1, 65535);
		sample_at(20'sd0, 20'sd0);
		sample_at(20'sd300, 20'sd77);
		sample_at(-20'sd524288, 20'sd524287);
		sample_at(20'sd255, -20'sd1);

		// Random phases over a range of register settings. Each sample also
		// fills its unwritten neighbors, so the beat count is several times
		// the phase length.
		configure(1'b0, 256);
		random_phase(36);
		configure(1'b1, 256);
		random_phase(20);
		configure(1'b0, 1);
		random_phase(28);
		configure(1'b1, 65535);
		random_phase(14);
		configure(1'b0, 65535);
		random_phase(24);
		configure(1'b1, 1);
		random_phase(10);
		configure(1'($urandom), $urandom_range(1, 65535));
		random_phase(20);

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Checked %0d interpolated pixels and %0d image writes", sb.samples_checked,
			sb.writes_seen);
		$display("across grayscale and three-channel modes, strides from 1 to 65535.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
